// ----- rtl/core/salsa_pkg.sv -----
// ----------------------------------------------------------------------------
// salsa_pkg
// Shared types, constants and helpers for the Salsa20/20 core block.
// ----------------------------------------------------------------------------
`default_nettype none

package salsa_pkg;

	localparam int DOUBLE_ROUNDS_DEF = 10;
	localparam int BLOCK_WORDS       = 16;
	localparam int WORD_W            = 32;
	localparam int LANES             = 4;

	// rotate amounts of the four quarter-round steps
	localparam int ROT_S0 = 7;
	localparam int ROT_S1 = 9;
	localparam int ROT_S2 = 13;
	localparam int ROT_S3 = 18;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [3:0]        widx_t;
	typedef logic [1:0]        sub_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;   // shift a new word into both stores
		logic step;   // run one quarter-round step on all four lanes
		sub_t sub;    // which of the four steps
		logic xpose;  // last step of a half round: transpose the state
		logic shift;  // result transaction taken: advance output word
	} dp_cmd_t;

	function automatic word_t rotl_step(word_t v, sub_t sub);
		word_t r;
		case (sub)
			2'd0: r = (v << ROT_S0) | (v >> (WORD_W - ROT_S0));
			2'd1: r = (v << ROT_S1) | (v >> (WORD_W - ROT_S1));
			2'd2: r = (v << ROT_S2) | (v >> (WORD_W - ROT_S2));
			default: r = (v << ROT_S3) | (v >> (WORD_W - ROT_S3));
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/salsa20_core_block_top.sv -----
// ----------------------------------------------------------------------------
// salsa20_core_block_top
// Salsa20 core: loads a 16-word block, runs the double rounds, emits 16 words.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  in      | in_valid / in_stall    | in_word[31:0]
//  out     | out_valid / out_stall  | out_word[31:0], out_last
//
//  Load takes 16 input transactions, one per cycle at best.
//  Compute runs 8 * DOUBLE_ROUNDS steps (80 by default): the four
//  quarter-round lanes do one add-rotate-xor step each per cycle.
//  Emit takes 16 output transactions.
//  Reset clears the controller only; the word stores are filled by loading.
//  in_stall is high outside the load phase; out_stall holds the current word.
// ----------------------------------------------------------------------------
`default_nettype none

module salsa20_core_block_top #(
	parameter int DOUBLE_ROUNDS = salsa_pkg::DOUBLE_ROUNDS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] in_word,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      out_word,
	output logic             out_last
);

	salsa_pkg::dp_cmd_t cmd;

	salsa_ctrl #(
		.DOUBLE_ROUNDS(DOUBLE_ROUNDS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_last  (out_last),
		.cmd       (cmd)
	);

	salsa_dp u_dp (
		.clk      (clk),
		.cmd      (cmd),
		.in_word  (in_word),
		.out_word (out_word)
	);

endmodule

`default_nettype wire

// ----- rtl/core/salsa_dp.sv -----
// ----------------------------------------------------------------------------
// salsa_dp
// Datapath: input and working stores, four quarter-round lanes, final add.
// ----------------------------------------------------------------------------
`default_nettype none

module salsa_dp (
	input  wire logic               clk,
	input  wire salsa_pkg::dp_cmd_t cmd,
	input  wire salsa_pkg::word_t   in_word,
	output salsa_pkg::word_t        out_word
);

	salsa_pkg::word_t orig_q [salsa_pkg::BLOCK_WORDS];
	salsa_pkg::word_t work_q [salsa_pkg::BLOCK_WORDS];
	salsa_pkg::word_t step_v [salsa_pkg::BLOCK_WORDS];
	salsa_pkg::word_t work_d [salsa_pkg::BLOCK_WORDS];

	// Each lane works on a column: lane q, position j sits at index {q+j, q}.
	// After a step the lane's four words rotate by one place, so the next
	// step acts on the same fixed positions. The transpose at the end of a
	// half round turns the next column round into a row round.
	always_comb begin
		logic [1:0]       k0, k1, k2, k3;
		salsa_pkg::word_t p0, p1, p2, p3;
		step_v = work_q;
		for (int q = 0; q < salsa_pkg::LANES; q++) begin
			k0 = 2'(q);
			k1 = 2'(q + 1);
			k2 = 2'(q + 2);
			k3 = 2'(q + 3);
			p0 = work_q[{k0, 2'(q)}];
			p1 = work_q[{k1, 2'(q)}];
			p2 = work_q[{k2, 2'(q)}];
			p3 = work_q[{k3, 2'(q)}];
			step_v[{k0, 2'(q)}] = p1 ^ salsa_pkg::rotl_step(p0 + p3, cmd.sub);
			step_v[{k1, 2'(q)}] = p2;
			step_v[{k2, 2'(q)}] = p3;
			step_v[{k3, 2'(q)}] = p0;
		end
		work_d = step_v;
		if (cmd.xpose) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					work_d[{2'(r), 2'(c)}] = step_v[{2'(c), 2'(r)}];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < salsa_pkg::BLOCK_WORDS - 1; i++) begin
				orig_q[i] <= orig_q[i+1];
				work_q[i] <= work_q[i+1];
			end
			orig_q[salsa_pkg::BLOCK_WORDS-1] <= in_word;
			work_q[salsa_pkg::BLOCK_WORDS-1] <= in_word;
		end else if (cmd.step) begin
			work_q <= work_d;
		end else if (cmd.shift) begin
			for (int i = 0; i < salsa_pkg::BLOCK_WORDS - 1; i++) begin
				orig_q[i] <= orig_q[i+1];
				work_q[i] <= work_q[i+1];
			end
			orig_q[salsa_pkg::BLOCK_WORDS-1] <= orig_q[0];
			work_q[salsa_pkg::BLOCK_WORDS-1] <= work_q[0];
		end
	end

	assign out_word = orig_q[0] + work_q[0];

endmodule

`default_nettype wire

// ----- rtl/core/salsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// salsa_ctrl
// Controller: load / run / emit sequencing and step, half-round and word counts.
// ----------------------------------------------------------------------------
`default_nettype none

module salsa_ctrl #(
	parameter int DOUBLE_ROUNDS = salsa_pkg::DOUBLE_ROUNDS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic               out_last,
	output salsa_pkg::dp_cmd_t cmd
);

	localparam int HALF_N = 2 * DOUBLE_ROUNDS;
	localparam int HALF_W = $clog2(HALF_N);

	typedef enum logic [2:0] {
		ST_LOAD = 3'b001,
		ST_RUN  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t              state_q, state_d;
	logic [3:0]          word_cnt_q;
	salsa_pkg::sub_t     sub_q;
	logic [HALF_W-1:0]   half_q;
	logic                in_acc, out_acc, last_half;

	assign in_acc    = in_valid && (state_q == ST_LOAD);
	assign out_acc   = (state_q == ST_EMIT) && !out_stall;
	assign last_half = (half_q == HALF_W'(HALF_N - 1));

	assign in_stall  = (state_q != ST_LOAD);
	assign out_valid = (state_q == ST_EMIT);
	assign out_last  = (word_cnt_q == 4'(salsa_pkg::BLOCK_WORDS - 1));

	assign cmd.load  = in_acc;
	assign cmd.step  = (state_q == ST_RUN);
	assign cmd.sub   = sub_q;
	assign cmd.xpose = (sub_q == 2'd3);
	assign cmd.shift = out_acc;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_acc && out_last) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (cmd.xpose && last_half) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_acc && out_last) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			word_cnt_q <= '0;
			sub_q      <= '0;
			half_q     <= '0;
		end else begin
			state_q <= state_d;
			// word count serves both the load and the emit phase
			if (in_acc || out_acc) word_cnt_q <= word_cnt_q + 4'd1;
			if (state_q == ST_RUN) begin
				sub_q <= sub_q + 2'd1;
				if (cmd.xpose) half_q <= last_half ? '0 : half_q + HALF_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_load_to_run: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && out_last) |=> (state_q == ST_RUN))
		else $error("run did not start after the sixteenth input word");

	a_emit_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && out_last) |=> (state_q == ST_LOAD && word_cnt_q == 4'd0))
		else $error("block did not return to load after last result");

	a_run_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_RUN) |-> (sub_q == 2'd0 && half_q == '0 && word_cnt_q == 4'd0))
		else $error("run entered with stale counters");

	a_half_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && cmd.xpose && !last_half) |=>
		(state_q == ST_RUN && half_q == $past(half_q) + HALF_W'(1)))
		else $error("half-round count did not advance");
`endif

endmodule

`default_nettype wire

// ----- tb/salsa20_core_block_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// salsa20_core_block_top_test
// Loads 16-word blocks into the Salsa20 core, word by word, and checks every
// emitted word and its last flag against an in-bench core calculation or a
// typed table result. Both channels idle and stall at random, and the output
// is held off for a long stretch so that the core fills up and blocks its input.
// ----------------------------------------------------------------------------
`default_nettype none

module salsa20_core_block_top_test;

	localparam int unsigned CYCLE_LIMIT  = 100000;
	localparam int unsigned DRAIN_CYCLES = 120;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned RAND_BLOCKS  = 11;
	localparam int unsigned DIR_ROWS     = 25;
	localparam int unsigned MAX_REPORTS  = 10;

	typedef salsa_pkg::word_t blk_t [salsa_pkg::BLOCK_WORDS];

	typedef struct packed {
		salsa_pkg::word_t word;
		logic             last;
	} out_xact_t;

	// typed = 1 on a block's last word: all 16 results equal typed_out
	typedef struct packed {
		salsa_pkg::word_t word;
		logic             typed;
		salsa_pkg::word_t typed_out;
	} dir_row_t;

	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		'{32'h0000_0000, 1'b0, 32'h0000_0000},
		'{32'h0000_0000, 1'b0, 32'h0000_0000},
		'{32'h0000_0000, 1'b0, 32'h0000_0000},
		'{32'h0000_0000, 1'b0, 32'h0000_0000},
		'{32'h0000_0000, 1'b0, 32'h0000_0000},
		'{32'h0000_0000, 1'b0, 32'h0000_0000},
		'{32'h0000_0000, 1'b0, 32'h0000_0000},
		'{32'h0000_0000, 1'b0, 32'h0000_0000},
		'{32'h0000_0000, 1'b0, 32'h0000_0000},
		'{32'h0000_0000, 1'b0, 32'h0000_0000},
		'{32'h0000_0000, 1'b0, 32'h0000_0000},
		'{32'h0000_0000, 1'b0, 32'h0000_0000},
		'{32'h0000_0000, 1'b0, 32'h0000_0000},
		'{32'h0000_0000, 1'b0, 32'h0000_0000},
		'{32'h0000_0000, 1'b0, 32'h0000_0000},
		'{32'h0000_0000, 1'b1, 32'h0000_0000},
		'{32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
		'{32'h8000_0000, 1'b0, 32'h0000_0000},
		'{32'h0000_0001, 1'b0, 32'h0000_0000},
		'{32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
		'{32'hFFFF_FFFE, 1'b0, 32'h0000_0000},
		'{32'hAAAA_AAAA, 1'b0, 32'h0000_0000},
		'{32'h5555_5555, 1'b0, 32'h0000_0000},
		'{32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
		'{32'h0000_0000, 1'b0, 32'h0000_0000}
	};

	// column round, then row round
	localparam int unsigned QR_IDX [8][4] = '{
		'{0, 4, 8, 12}, '{5, 9, 13, 1}, '{10, 14, 2, 6}, '{15, 3, 7, 11},
		'{0, 1, 2, 3}, '{5, 6, 7, 4}, '{10, 11, 8, 9}, '{15, 12, 13, 14}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] in_word;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] out_word;
	logic        out_last;

	blk_t        loaded_words;
	int unsigned load_idx = 0;
	out_xact_t   pending_words [$];
	int unsigned fail_cnt = 0;
	int unsigned cycle_cnt = 0;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	bit          hold_req = 1'b0;
	int unsigned hold_left = 0;

	salsa20_core_block_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.out_last  (out_last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic salsa_pkg::word_t rotl(salsa_pkg::word_t v, int unsigned n);
		return (v << n) | (v >> (salsa_pkg::WORD_W - n));
	endfunction

	function automatic blk_t salsa_core_words(blk_t x);
		blk_t        s;
		int unsigned a, b, c, d;
		s = x;
		for (int r = 0; r < salsa_pkg::DOUBLE_ROUNDS_DEF; r++) begin
			for (int q = 0; q < 8; q++) begin
				a = QR_IDX[q][0];
				b = QR_IDX[q][1];
				c = QR_IDX[q][2];
				d = QR_IDX[q][3];
				s[b] = s[b] ^ rotl(s[a] + s[d], salsa_pkg::ROT_S0);
				s[c] = s[c] ^ rotl(s[b] + s[a], salsa_pkg::ROT_S1);
				s[d] = s[d] ^ rotl(s[c] + s[b], salsa_pkg::ROT_S2);
				s[a] = s[a] ^ rotl(s[d] + s[c], salsa_pkg::ROT_S3);
			end
		end
		for (int i = 0; i < salsa_pkg::BLOCK_WORDS; i++)
			s[i] = s[i] + x[i];
		return s;
	endfunction

	// store one accepted word; on the block's last word queue all 16 results
	function automatic void absorb_word(salsa_pkg::word_t w, logic typed,
		salsa_pkg::word_t typed_out);
		blk_t      res;
		out_xact_t x;
		loaded_words[load_idx] = w;
		if (load_idx == salsa_pkg::BLOCK_WORDS - 1) begin
			res = salsa_core_words(loaded_words);
			for (int i = 0; i < salsa_pkg::BLOCK_WORDS; i++) begin
				x.word = typed ? typed_out : res[i];
				x.last = (i == salsa_pkg::BLOCK_WORDS - 1);
				pending_words.push_back(x);
			end
		end
		load_idx = (load_idx + 1) % salsa_pkg::BLOCK_WORDS;
	endfunction

	function automatic salsa_pkg::word_t pick_word();
		salsa_pkg::word_t w;
		case ($urandom_range(0, 9))
			0: w = '0;
			1: w = '1;
			2: w = salsa_pkg::word_t'(1) << $urandom_range(0, salsa_pkg::WORD_W - 1);
			3: w = ~(salsa_pkg::word_t'(1) << $urandom_range(0, salsa_pkg::WORD_W - 1));
			default: w = $urandom;
		endcase
		return w;
	endfunction

	// enter and leave at a falling edge
	task automatic drive_word(salsa_pkg::word_t w, logic typed,
		salsa_pkg::word_t typed_out);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		@(posedge clk);
		while (in_stall) begin
			@(negedge clk);
			@(posedge clk);
		end
		absorb_word(w, typed, typed_out);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && hold_left == 0) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		out_xact_t exp_x;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= MAX_REPORTS)
					$display("unexpected output transaction: word %h last %b",
						out_word, out_last);
			end else begin
				exp_x = pending_words.pop_front();
				if (out_word !== exp_x.word || out_last !== exp_x.last) begin
					fail_cnt++;
					if (fail_cnt <= MAX_REPORTS)
						$display("mismatch: expected word %h last %b, got word %h last %b",
							exp_x.word, exp_x.last, out_word, out_last);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_word  = '0;
		send_idle_pct = 9;
		recv_idle_pct = 76;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			drive_word(DIR_TABLE[i].word, DIR_TABLE[i].typed, DIR_TABLE[i].typed_out);

		// complete the block the table left open
		while (load_idx != 0)
			drive_word(pick_word(), 1'b0, '0);

		for (int unsigned blk = 0; blk < RAND_BLOCKS; blk++) begin
			if (blk == RAND_BLOCKS / 3) begin
				// pause the input until the core has emitted everything
				in_valid <= 1'b0;
				@(negedge clk);
				wait_drained();
				send_idle_pct = 76;
				recv_idle_pct = 9;
			end
			if (blk == 2 * RAND_BLOCKS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				hold_req      = 1'b1;
			end
			for (int i = 0; i < salsa_pkg::BLOCK_WORDS; i++)
				drive_word(pick_word(), 1'b0, '0);
		end

		in_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_cnt == 0 && pending_words.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

// ----- salsa20_core_block_top.f -----
rtl/core/salsa_pkg.sv
rtl/core/salsa_dp.sv
rtl/core/salsa_ctrl.sv
rtl/core/salsa20_core_block_top.sv
tb/salsa20_core_block_top_test.sv
